// ----- design/modexp_pkg.sv -----
// Shared widths, register indexes and reset values for the modular exponentiation block.
package modexp_pkg;

  // Fixed field widths
  localparam int BASE_BITS = 63;
  localparam int OUT_BITS  = 32;
  localparam int CFG_BITS  = 32;
  localparam int IDX_BITS  = 2;

  // Counter wide enough for the base reduction sweep (also covers modulus widths up to 64 bits)
  localparam int CNT_W = $clog2(BASE_BITS);

  // Configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_MODULUS  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_EXPONENT = 2'd1;

  // Reset values of the key registers
  localparam logic [CFG_BITS-1:0] RST_MODULUS  = 32'd3233;
  localparam logic [CFG_BITS-1:0] RST_EXPONENT = 32'd17;

endpackage

// ----- design/modular_exponentiation.sv -----
// Sequence from acceptance to result: the base reduction sweep, then per exponent bit a scan
// step, a bit-serial multiply on a set bit and a bit-serial square below the highest set bit,
// then a done state; a zero exponent goes from the scan to done, a zero modulus skips to done.
// Throughput: one item at a time; the next item is taken the cycle after the result enters the
// output register.
// Synchronous active-high reset clears control state and restores modulus 3233, exponent 17.
module modular_exponentiation #(
  parameter int MOD_BITS = 32,
  parameter int EXP_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 wr_en,
  input  logic [modexp_pkg::IDX_BITS-1:0]      wr_index,
  input  logic [modexp_pkg::CFG_BITS-1:0]      wr_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [modexp_pkg::BASE_BITS-1:0]     base,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [modexp_pkg::OUT_BITS-1:0]      power
);

  localparam int CNT_W = modexp_pkg::CNT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_REDUCE  = 3'd1;
  localparam logic [2:0] S_NEXT    = 3'd2;
  localparam logic [2:0] S_MUL_ACC = 3'd3;
  localparam logic [2:0] S_MUL_SQ  = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]                          state;
  logic [MOD_BITS-1:0]                 modulus;
  logic [EXP_BITS-1:0]                 exponent;
  logic [modexp_pkg::BASE_BITS-1:0]    base_sr;
  logic [EXP_BITS-1:0]                 exp_sr;
  logic [MOD_BITS-1:0]                 acc;
  logic [MOD_BITS-1:0]                 sq;
  logic [MOD_BITS-1:0]                 mx;
  logic [MOD_BITS-1:0]                 my;
  logic [MOD_BITS-1:0]                 mr;
  logic [CNT_W-1:0]                    cnt;

  logic                                in_take;
  logic                                out_free;
  logic [MOD_BITS:0]                   rt;
  logic [MOD_BITS-1:0]                 rred;
  logic [MOD_BITS+1:0]                 madd;
  logic [MOD_BITS+1:0]                 mt;
  logic [MOD_BITS+1:0]                 m1;
  logic [MOD_BITS+1:0]                 m2;
  logic [MOD_BITS+1:0]                 mwide;
  logic [MOD_BITS-1:0]                 mred;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Base reduction step: shift in one base bit, subtract modulus once if needed
  assign rt = {mr, base_sr[modexp_pkg::BASE_BITS-1]};
  always_comb begin
    if (rt >= {1'b0, modulus}) begin
      rred = MOD_BITS'(rt - {1'b0, modulus});
    end else begin
      rred = rt[MOD_BITS-1:0];
    end
  end

  // Multiplier step: double the partial, add the multiplicand on a set bit, reduce below m
  assign m1   = {2'b00, modulus};
  assign m2   = {1'b0, modulus, 1'b0};
  assign madd = my[MOD_BITS-1] ? {2'b00, mx} : '0;
  assign mt   = {1'b0, mr, 1'b0} + madd;
  always_comb begin
    priority if (mt >= m2) begin
      mwide = mt - m2;
    end else if (mt >= m1) begin
      mwide = mt - m1;
    end else begin
      mwide = mt;
    end
  end
  assign mred = mwide[MOD_BITS-1:0];

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= modexp_pkg::RST_MODULUS[MOD_BITS-1:0];
      exponent <= modexp_pkg::RST_EXPONENT[EXP_BITS-1:0];
    end else if (wr_en) begin
      if (wr_index == modexp_pkg::REG_MODULUS) begin
        modulus <= wr_data[MOD_BITS-1:0];
      end else if (wr_index == modexp_pkg::REG_EXPONENT) begin
        exponent <= wr_data[EXP_BITS-1:0];
      end
    end
  end

  // Sequencer: reduce the base, then scan the exponent with square and multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            base_sr <= base;
            mr      <= '0;
            cnt     <= CNT_W'(modexp_pkg::BASE_BITS - 1);
            if (modulus == '0) begin
              acc   <= '0;
              state <= S_DONE;
            end else begin
              acc   <= (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          mr      <= rred;
          base_sr <= base_sr << 1;
          cnt     <= cnt - 1'b1;
          if (cnt == '0) begin
            sq     <= rred;
            exp_sr <= exponent;
            state  <= S_NEXT;
          end
        end
        S_NEXT: begin
          mr  <= '0;
          cnt <= CNT_W'(MOD_BITS - 1);
          if (exp_sr == '0) begin
            state <= S_DONE;
          end else if (exp_sr[0]) begin
            mx    <= acc;
            my    <= sq;
            state <= S_MUL_ACC;
          end else begin
            mx    <= sq;
            my    <= sq;
            state <= S_MUL_SQ;
          end
        end
        S_MUL_ACC: begin
          mr  <= mred;
          my  <= my << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            acc <= mred;
            // skip the last square when no higher exponent bit remains
            if ((exp_sr >> 1) == '0) begin
              state <= S_DONE;
            end else begin
              mx    <= sq;
              my    <= sq;
              mr    <= '0;
              cnt   <= CNT_W'(MOD_BITS - 1);
              state <= S_MUL_SQ;
            end
          end
        end
        S_MUL_SQ: begin
          mr  <= mred;
          my  <= my << 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            sq     <= mred;
            exp_sr <= exp_sr >> 1;
            state  <= S_NEXT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load the result when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      power <= modexp_pkg::OUT_BITS'(acc);
    end
  end

endmodule
